[rtl/core/ffcc_pkg.sv]
// Shared types and constants for the fingertip force contact conditioner.
// No dependencies; imported by ffcc_isqrt, the top level, the checker and the testbench.
`default_nettype none

package ffcc_pkg;

  // Field widths
  localparam int IDX_W   = 3;
  localparam int FORCE_W = 24;
  localparam int PROB_W  = 16;
  localparam int MAG_W   = 24;
  localparam int RATE_W  = 48;
  localparam int ALPHA_W = 17;
  localparam int INVDT_W = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int SQR_W  = 2 * FORCE_W - 1;     // one squared component
  localparam int SQ_W   = 2 * MAG_W;           // sum of squares
  localparam int SQ_TW  = SQ_W + 1;            // root trial term
  localparam int DIFF_W = MAG_W + 1;
  localparam int RAW_W  = DIFF_W + INVDT_W;
  localparam int OLD_W  = RAW_W + 1;
  localparam int ACC_W  = OLD_W + ALPHA_W + 2;
  localparam int FRAC_W = 16;

  // Square root pipeline: root bits resolved per stage
  localparam int ROOT_STEP   = 3;
  localparam int ROOT_STAGES = MAG_W / ROOT_STEP;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NATIVE_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_ALPHA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DT      = 3'd4;

  // Register reset values
  localparam logic [PROB_W-1:0]  CONTACT_THR_RST = 16'd32768;
  localparam logic [ALPHA_W-1:0] RATE_ALPHA_RST  = 17'd6554;
  localparam logic [INVDT_W-1:0] INV_DT_RST      = 16'd500;

  // Arithmetic constants
  localparam logic [ALPHA_W-1:0]       ALPHA_ONE  = 17'd65536;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(32768);
  localparam logic signed [RATE_W-1:0] RAW_BOUND  = 48'sh0100_0000_0000;
  localparam logic signed [RATE_W-1:0] RAW_FLOOR  = -RAW_BOUND;

  // Side information that rides along with the magnitude computation
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [PROB_W-1:0] lvl;
    logic              pgood;
    logic              last;
  } meta_t;

endpackage

`default_nettype wire

[rtl/core/ffcc_isqrt.sv]
// Pipelined integer square root, ROOT_STEP root bits per stage.
// Depends on ffcc_pkg (widths, meta_t).
`default_nettype none

module ffcc_isqrt import ffcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SQ_W-1:0]  in_sq,
  input  meta_t            in_meta,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [MAG_W-1:0] out_root,
  output meta_t            out_meta
);

  logic             v        [ROOT_STAGES];
  logic             can_load [ROOT_STAGES];
  logic [SQ_W-1:0]  rem      [ROOT_STAGES-1];
  logic [MAG_W-1:0] root     [ROOT_STAGES];
  meta_t            meta     [ROOT_STAGES];

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    localparam int TOP_BIT = MAG_W - 1 - s * ROOT_STEP;

    logic             v_src;
    logic [SQ_W-1:0]  rem_src;
    logic [SQ_W-1:0]  rem_next;
    logic [MAG_W-1:0] root_src;
    logic [MAG_W-1:0] root_next;
    meta_t            meta_src;
    logic [SQ_TW-1:0] trial;

    if (s == 0) begin : g_head
      assign v_src    = in_valid;
      assign rem_src  = in_sq;
      assign root_src = '0;
      assign meta_src = in_meta;
    end else begin : g_body
      assign v_src    = v[s-1];
      assign rem_src  = rem[s-1];
      assign root_src = root[s-1];
      assign meta_src = meta[s-1];
    end

    if (s == ROOT_STAGES - 1) begin : g_tail
      assign can_load[s] = !v[s] || !out_stall;
    end else begin : g_mid
      assign can_load[s] = !v[s] || can_load[s+1];
    end

    // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i); take the bit when it fits
    always_comb begin
      rem_next  = rem_src;
      root_next = root_src;
      trial     = '0;
      for (int j = 0; j < ROOT_STEP; j++) begin
        trial = (SQ_TW'(root_next) << (TOP_BIT - j + 1)) +
                (SQ_TW'(1) << (2 * (TOP_BIT - j)));
        if ({1'b0, rem_next} >= trial) begin
          rem_next = rem_next - trial[SQ_W-1:0];
          root_next[TOP_BIT - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (can_load[s]) begin
        v[s] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (can_load[s] && v_src) begin
        root[s] <= root_next;
        meta[s] <= meta_src;
      end
    end

    if (s < ROOT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (can_load[s] && v_src) begin
          rem[s] <= rem_next;
        end
      end
    end
  end

  assign in_stall  = !can_load[0];
  assign out_valid = v[ROOT_STAGES-1];
  assign out_root  = root[ROOT_STAGES-1];
  assign out_meta  = meta[ROOT_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/fingertip_force_contact_conditioner_unit.sv]
// Top level of the fingertip force contact conditioner: magnitude, contact and rate.
// Depends on ffcc_pkg and ffcc_isqrt.
`default_nettype none

// One fingertip sample enters per request and one result leaves per request, in order.
// The block accepts a new request every clock cycle unless in_stall is high; on the way to the
// output register one stage squares the three force components, one sums them,
// eight stages of the square root resolve three root bits each, then one stage forms the
// contact decision and the magnitude difference, one multiplies by inv_dt, and one blends
// the EMA and drives the output registers. The square root pipeline sets the depth.
// Per-fingertip state lives in flip-flops cleared by reset, so there is no clearing pass
// and requests for the same fingertip may follow each other in consecutive cycles: the
// previous magnitude is read and replaced in the difference stage, the stored rate in the
// output stage. A stall on the output backs up through the pipeline one bubble at a time,
// so in_stall rises only when every stage holds a request. Configuration registers are
// read live and must be written while the pipeline is empty.

module fingertip_force_contact_conditioner_unit import ffcc_pkg::*; #(
  parameter int FINGERTIPS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // sample input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IDX_W-1:0]         finger_index,
  input  logic                     sample_valid,
  input  logic signed [FORCE_W-1:0] force_x,
  input  logic signed [FORCE_W-1:0] force_y,
  input  logic signed [FORCE_W-1:0] force_z,
  input  logic [PROB_W-1:0]        contact_prob,
  input  logic                     last_in_tick,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_index,
  output logic [MAG_W-1:0]         magnitude,
  output logic                     touching,
  output logic [PROB_W-1:0]        contact_level,
  output logic signed [RATE_W-1:0] mag_rate
);

  localparam int FW = (FINGERTIPS > 1) ? $clog2(FINGERTIPS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]   force_limit;
  logic [PROB_W-1:0]  contact_limit;
  logic               native_contact_mode;
  logic [ALPHA_W-1:0] rate_alpha;
  logic [INVDT_W-1:0] inv_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_limit         <= '0;
      contact_limit       <= CONTACT_THR_RST;
      native_contact_mode <= 1'b0;
      rate_alpha          <= RATE_ALPHA_RST;
      inv_dt              <= INV_DT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORCE_THR:   force_limit         <= cfg_data[MAG_W-1:0];
        REG_CONTACT_THR: contact_limit       <= cfg_data[PROB_W-1:0];
        REG_NATIVE_MODE: native_contact_mode <= cfg_data[0];
        REG_RATE_ALPHA:  rate_alpha          <= cfg_data[ALPHA_W-1:0];
        REG_INV_DT:      inv_dt              <= cfg_data[INVDT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: each stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic can_0, can_1, can_m, can_r, can_o;
  logic isq_stall;

  logic s0_v, s1_v, q_v, m_v, r_v;

  assign can_o    = !out_valid || !out_stall;
  assign can_r    = !r_v || can_o;
  assign can_m    = !m_v || can_r;
  assign can_1    = !s1_v || !isq_stall;
  assign can_0    = !s0_v || can_1;
  assign in_stall = !can_0;

  // ---------------------------------------------------------------------------
  // Stage 0: square the components. An invalid sample squares zeros, which
  // yields magnitude 0 and therefore no force contact further down.
  // ---------------------------------------------------------------------------
  logic signed [FORCE_W-1:0]   fx, fy, fz;
  logic signed [2*FORCE_W-1:0] px, py, pz;
  logic [SQR_W-1:0]            s0_sqx, s0_sqy, s0_sqz;
  meta_t                       s0_meta;
  meta_t                       in_meta;
  logic                        native;

  assign fx = sample_valid ? force_x : '0;
  assign fy = sample_valid ? force_y : '0;
  assign fz = sample_valid ? force_z : '0;
  assign px = fx * fx;
  assign py = fy * fy;
  assign pz = fz * fz;

  assign native        = sample_valid && native_contact_mode;
  assign in_meta.idx   = finger_index;
  assign in_meta.lvl   = native ? contact_prob : '0;
  assign in_meta.pgood = !native || (contact_prob > contact_limit);
  assign in_meta.last  = last_in_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (can_0) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_0 && in_valid) begin
      s0_sqx  <= px[SQR_W-1:0];
      s0_sqy  <= py[SQR_W-1:0];
      s0_sqz  <= pz[SQR_W-1:0];
      s0_meta <= in_meta;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: sum of squares, at most 3 * 2^46 so it fits the root input
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] s1_sq;
  meta_t           s1_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (can_1) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (can_1 && s0_v) begin
      s1_sq   <= SQ_W'(s0_sqx) + SQ_W'(s0_sqy) + SQ_W'(s0_sqz);
      s1_meta <= s0_meta;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root pipeline
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] q_root;
  meta_t            q_meta;

  ffcc_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_v),
    .in_stall  (isq_stall),
    .in_sq     (s1_sq),
    .in_meta   (s1_meta),
    .out_valid (q_v),
    .out_stall (!can_m),
    .out_root  (q_root),
    .out_meta  (q_meta)
  );

  // ---------------------------------------------------------------------------
  // Stage M: contact decision, read and replace the previous magnitude
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]         prev_mag [FINGERTIPS];
  logic [FW-1:0]            q_fidx;
  logic                     q_inr;
  logic signed [DIFF_W-1:0] q_diff;

  logic [IDX_W-1:0]         m_idx;
  logic [PROB_W-1:0]        m_lvl;
  logic                     m_last;
  logic                     m_inr;
  logic [MAG_W-1:0]         m_mag;
  logic                     m_contact;
  logic signed [DIFF_W-1:0] m_diff;

  assign q_fidx = FW'(q_meta.idx);
  assign q_inr  = int'(q_meta.idx) < FINGERTIPS;
  assign q_diff = $signed({1'b0, q_root}) - $signed({1'b0, prev_mag[q_fidx]});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (can_m) begin
      m_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (can_m && q_v) begin
      m_idx     <= q_meta.idx;
      m_lvl     <= q_meta.lvl;
      m_last    <= q_meta.last;
      m_inr     <= q_inr;
      m_mag     <= q_root;
      m_contact <= (q_root > force_limit) && q_meta.pgood;
      m_diff    <= q_diff;
    end
  end

  // Replace the magnitude as the request moves on, so a following request for
  // the same fingertip already sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FINGERTIPS; i++) begin
        prev_mag[i] <= '0;
      end
    end else if (can_m && q_v && q_inr) begin
      prev_mag[q_fidx] <= q_root;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage R: raw rate = difference * inv_dt, |raw| < 2^40
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]        r_idx;
  logic [PROB_W-1:0]       r_lvl;
  logic                    r_last;
  logic                    r_inr;
  logic [MAG_W-1:0]        r_mag;
  logic                    r_contact;
  logic signed [RAW_W-1:0] r_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (can_r) begin
      r_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (can_r && m_v) begin
      r_idx     <= m_idx;
      r_lvl     <= m_lvl;
      r_last    <= m_last;
      r_inr     <= m_inr;
      r_mag     <= m_mag;
      r_contact <= m_contact;
      r_raw     <= m_diff * $signed({1'b0, inv_dt});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage O: EMA blend with the stored rate, round half up, drive outputs
  // ---------------------------------------------------------------------------
  logic signed [RATE_W-1:0] rate_store [FINGERTIPS];
  logic                     rate_started;
  logic [FW-1:0]            r_fidx;
  logic [ALPHA_W-1:0]       alpha_eff;
  logic [ALPHA_W-1:0]       alpha_inv;
  logic signed [RATE_W-1:0] old_rate;
  logic signed [OLD_W-1:0]  old_clamp;
  logic signed [ACC_W-1:0]  prod_new;
  logic signed [ACC_W-1:0]  prod_old;
  logic signed [ACC_W-1:0]  blend;
  logic signed [RATE_W-1:0] rate_blend;
  logic signed [RATE_W-1:0] rate_next;

  assign r_fidx    = FW'(r_idx);
  assign alpha_eff = (rate_alpha > ALPHA_ONE) ? ALPHA_ONE : rate_alpha;
  assign alpha_inv = ALPHA_ONE - alpha_eff;
  assign old_rate  = rate_store[r_fidx];

  always_comb begin
    if (old_rate > RAW_BOUND) begin
      old_clamp = RAW_BOUND[OLD_W-1:0];
    end else if (old_rate < RAW_FLOOR) begin
      old_clamp = RAW_FLOOR[OLD_W-1:0];
    end else begin
      old_clamp = old_rate[OLD_W-1:0];
    end
  end

  assign prod_new = $signed({1'b0, alpha_eff}) * r_raw;
  assign prod_old = $signed({1'b0, alpha_inv}) * old_clamp;
  assign blend    = prod_new + prod_old + ROUND_HALF;

  // Both blend inputs lie within +-2^40, so the rounded result does too and
  // the 48-bit saturation bound is never reached: sign extension suffices.
  assign rate_blend = RATE_W'($signed(blend[ACC_W-1:FRAC_W]));
  assign rate_next  = (rate_started && r_inr) ? rate_blend : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_o) begin
      out_valid <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (can_o && r_v) begin
      out_index     <= r_idx;
      magnitude     <= r_mag;
      touching      <= r_contact;
      contact_level <= r_lvl;
      mag_rate      <= rate_next;
    end
  end

  // Hold the rate at zero through the first tick; arm after its last sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_started <= 1'b0;
      for (int i = 0; i < FINGERTIPS; i++) begin
        rate_store[i] <= '0;
      end
    end else if (can_o && r_v) begin
      if (r_last) begin
        rate_started <= 1'b1;
      end
      if (r_inr) begin
        rate_store[r_fidx] <= rate_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The input side stalls only when the whole pipeline is full and blocked.
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised while the pipeline has room");

  // A request that leaves during the first tick carries a zero rate.
  a_first_tick_zero : assert property (@(posedge clk) disable iff (rst)
    (can_o && r_v && !rate_started) |=> (mag_rate == '0))
    else $error("nonzero mag_rate during the first tick");

  // The blended rate stays inside the raw rate bound.
  a_rate_bounded : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mag_rate <= RAW_BOUND) && (mag_rate >= RAW_FLOOR)))
    else $error("mag_rate outside the raw rate bound");

endmodule

`default_nettype wire

[dv/contact_result_checker.sv]
// Checker for the fingertip force contact conditioner: predicts each result and compares.
// Depends on ffcc_pkg; watches the register port and both request channels of the block.
module contact_result_checker import ffcc_pkg::*; #(
  parameter int FINGERTIPS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [IDX_W-1:0]          finger_index,
  input  logic                      sample_valid,
  input  logic signed [FORCE_W-1:0] force_x,
  input  logic signed [FORCE_W-1:0] force_y,
  input  logic signed [FORCE_W-1:0] force_z,
  input  logic [PROB_W-1:0]         contact_prob,
  input  logic                      last_in_tick,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [IDX_W-1:0]          out_index,
  input  logic [MAG_W-1:0]          magnitude,
  input  logic                      touching,
  input  logic [PROB_W-1:0]         contact_level,
  input  logic signed [RATE_W-1:0]  mag_rate,
  output int                        mismatches,
  output int                        outstanding,
  output int                        compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ALPHA_FULL = 65536;
  localparam longint PRIOR_LIMIT = 64'sh0000_0100_0000_0000;
  localparam longint RATE_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint RATE_LO = -RATE_HI - 1;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic [MAG_W-1:0]         mag;
    logic                     contact;
    logic [PROB_W-1:0]        level;
    logic signed [RATE_W-1:0] rate;
  } sample_result_t;

  sample_result_t pending_results[$];
  sample_result_t want;

  logic [MAG_W-1:0]   force_thr;
  logic [PROB_W-1:0]  contact_thr;
  logic               native_mode;
  logic [ALPHA_W-1:0] alpha;
  logic [INVDT_W-1:0] inv_dt;

  logic [MAG_W-1:0]         last_mag [FINGERTIPS];
  logic signed [RATE_W-1:0] smoothed_rate [FINGERTIPS];
  logic                     tick_seen;

  int bad_count;
  int seen_count;

  // Build the root bit by bit from the top: keep a bit while its square still fits.
  function automatic logic [MAG_W-1:0] root_floor(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n)
        root = trial;
    end
    return root[MAG_W-1:0];
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo)
      return lo;
    if (v > hi)
      return hi;
    return v;
  endfunction

  task automatic predict_sample(input logic [IDX_W-1:0] idx, input logic valid,
                                input logic signed [FORCE_W-1:0] fx,
                                input logic signed [FORCE_W-1:0] fy,
                                input logic signed [FORCE_W-1:0] fz,
                                input logic [PROB_W-1:0] prob, input logic last);
    sample_result_t r;
    longint sx, sy, sz, a, diff, raw, prior, blend, rounded;
    r = '0;
    r.idx = idx;
    if (valid) begin
      sx = fx;
      sy = fy;
      sz = fz;
      r.mag = root_floor(sx * sx + sy * sy + sz * sz);
      r.contact = (r.mag > force_thr) && (!native_mode || prob > contact_thr);
      if (native_mode)
        r.level = prob;
    end
    // Fingertip state moves only for indexes the block keeps.
    if (idx < FINGERTIPS) begin
      if (tick_seen) begin
        a = (alpha > ALPHA_FULL) ? ALPHA_FULL : longint'(alpha);
        diff = longint'(r.mag) - longint'(last_mag[idx]);
        raw = diff * longint'(inv_dt);
        prior = clip(longint'(smoothed_rate[idx]), -PRIOR_LIMIT, PRIOR_LIMIT);
        blend = a * raw + (ALPHA_FULL - a) * prior;
        rounded = clip((blend + 32768) >>> 16, RATE_LO, RATE_HI);
        r.rate = rounded[RATE_W-1:0];
      end
      smoothed_rate[idx] = r.rate;
      last_mag[idx] = r.mag;
    end
    if (last)
      tick_seen = 1'b1;
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      force_thr = '0;
      contact_thr = CONTACT_THR_RST;
      native_mode = 1'b0;
      alpha = RATE_ALPHA_RST;
      inv_dt = INV_DT_RST;
      for (int i = 0; i < FINGERTIPS; i++) begin
        last_mag[i] = '0;
        smoothed_rate[i] = '0;
      end
      tick_seen = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FORCE_THR:   force_thr = cfg_data[MAG_W-1:0];
          REG_CONTACT_THR: contact_thr = cfg_data[PROB_W-1:0];
          REG_NATIVE_MODE: native_mode = cfg_data[0];
          REG_RATE_ALPHA:  alpha = cfg_data[ALPHA_W-1:0];
          REG_INV_DT:      inv_dt = cfg_data[INVDT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        seen_count++;
        if (pending_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected result, index %0d magnitude %0h rate %0h",
                     $realtime, out_index, magnitude, mag_rate);
        end else begin
          want = pending_results.pop_front();
          if (want.idx !== out_index || want.mag !== magnitude ||
              want.contact !== touching || want.level !== contact_level ||
              want.rate !== mag_rate) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: result mismatch, result %0d", $realtime, seen_count);
              $display("  expected idx %0d mag %0h contact %0b level %0h rate %0h",
                       want.idx, want.mag, want.contact, want.level, want.rate);
              $display("  actual   idx %0d mag %0h contact %0b level %0h rate %0h",
                       out_index, magnitude, touching, contact_level, mag_rate);
            end
          end
        end
      end

      if (in_valid && !in_stall)
        predict_sample(finger_index, sample_valid, force_x, force_y, force_z,
                       contact_prob, last_in_tick);
    end
    mismatches <= bad_count;
    outstanding <= pending_results.size();
    compared <= seen_count;
  end

endmodule

[dv/tb_top.sv]
// Testbench top for the fingertip force contact conditioner: clock, reset, stimulus, verdict.
// Depends on ffcc_pkg, fingertip_force_contact_conditioner_unit and contact_result_checker.
module tb_top import ffcc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FINGERS        = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 142;
  localparam int TAIL_CYCLES    = 20;   // pipeline is 13 deep; leave margin
  localparam int HOLD_CYCLES    = 150;  // long output hold to back the pipeline up
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [FORCE_W-1:0] MAXF = 24'sh7FFFFF;
  localparam logic signed [FORCE_W-1:0] MINF = 24'sh800000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [IDX_W-1:0]          finger_index;
  logic                      sample_valid;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic signed [FORCE_W-1:0] force_z;
  logic [PROB_W-1:0]         contact_prob;
  logic                      last_in_tick;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [IDX_W-1:0]          out_index;
  logic [MAG_W-1:0]          magnitude;
  logic                      touching;
  logic [PROB_W-1:0]         contact_level;
  logic signed [RATE_W-1:0]  mag_rate;

  int mismatches;
  int outstanding;
  int compared;

  int tx_gap_max;          // sender idle per request, drawn from 0..tx_gap_max
  int rx_wait_max;         // receiver stall per result, drawn from 0..rx_wait_max
  int rx_wait_left = 0;
  int rx_hold_left = 0;
  int results_taken = 0;
  int samples_sent = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  logic [PROB_W-1:0] cur_contact_thr;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  fingertip_force_contact_conditioner_unit #(.FINGERTIPS(FINGERS)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .finger_index(finger_index), .sample_valid(sample_valid),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .contact_prob(contact_prob), .last_in_tick(last_in_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_index(out_index), .magnitude(magnitude), .touching(touching),
    .contact_level(contact_level), .mag_rate(mag_rate)
  );

  contact_result_checker #(.FINGERTIPS(FINGERS)) results_chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .finger_index(finger_index), .sample_valid(sample_valid),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .contact_prob(contact_prob), .last_in_tick(last_in_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_index(out_index), .magnitude(magnitude), .touching(touching),
    .contact_level(contact_level), .mag_rate(mag_rate),
    .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
  );

  // Receiver: after each accepted result, stall for a random count of cycles.
  // At a few points hold off for a long stretch so the pipeline fills and the
  // block stalls its input while the sender keeps offering requests.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_taken++;
        if (results_taken == 250 || results_taken == 500 || results_taken == 900)
          rx_hold_left = HOLD_CYCLES;
        else
          rx_wait_left = $urandom_range(0, rx_wait_max);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait_left > 0) begin
        rx_wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles, %0d results awaited",
               idle_cycles, outstanding);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request: idle a random gap, present it, hold it until accepted.
  // Drop valid only when a gap follows, so back-to-back requests keep it high.
  task automatic offer_sample(input logic [IDX_W-1:0] idx, input logic valid,
                              input logic signed [FORCE_W-1:0] fx,
                              input logic signed [FORCE_W-1:0] fy,
                              input logic signed [FORCE_W-1:0] fz,
                              input logic [PROB_W-1:0] prob, input logic last);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    finger_index <= idx;
    sample_valid <= valid;
    force_x      <= fx;
    force_y      <= fy;
    force_z      <= fz;
    contact_prob <= prob;
    last_in_tick <= last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [MAG_W-1:0] thr, input logic [PROB_W-1:0] cthr,
                               input logic native, input logic [ALPHA_W-1:0] a,
                               input logic [INVDT_W-1:0] idt);
    write_reg(REG_FORCE_THR, CFG_W'(thr));
    write_reg(REG_CONTACT_THR, CFG_W'(cthr));
    write_reg(REG_NATIVE_MODE, CFG_W'(native));
    write_reg(REG_RATE_ALPHA, CFG_W'(a));
    write_reg(REG_INV_DT, CFG_W'(idt));
    cfg_write <= 1'b0;
    cur_contact_thr = cthr;
    settings_used++;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Force component: mostly random with a random scale so magnitudes spread
  // over the whole range, with the extremes and zero mixed in.
  function automatic logic signed [FORCE_W-1:0] rand_force();
    logic signed [FORCE_W-1:0] v;
    v = FORCE_W'($urandom);
    case ($urandom_range(0, 11))
      0:       v = MINF;
      1:       v = MAXF;
      2:       v = '0;
      default: v = v >>> $urandom_range(0, FORCE_W - 1);
    endcase
    return v;
  endfunction

  // Probability: extremes, values next to the contact threshold, or anything.
  function automatic logic [PROB_W-1:0] rand_prob();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return cur_contact_thr + PROB_W'($urandom_range(0, 4)) - PROB_W'(2);
      default: return PROB_W'($urandom);
    endcase
  endfunction

  function automatic logic [MAG_W-1:0] rand_threshold();
    return MAG_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, MAG_W - 1));
  endfunction

  // Mostly whole ticks (every fingertip in order, last one flagged), the rest
  // stray requests with random index, valid bit and tick flag.
  task automatic run_ticks(input int quota);
    int sent;
    int f;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 99) < 85) begin
        for (f = 0; f < FINGERS; f++)
          offer_sample(IDX_W'(f), $urandom_range(0, 9) != 0, rand_force(), rand_force(),
                       rand_force(), rand_prob(), f == FINGERS - 1);
        sent += FINGERS;
      end else begin
        offer_sample(IDX_W'($urandom_range(0, FINGERS - 1)), 1'($urandom_range(0, 1)),
                     rand_force(), rand_force(), rand_force(), rand_prob(),
                     $urandom_range(0, 3) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    int p;
    // Hold every input at a known value from time zero.
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    finger_index <= '0;
    sample_valid <= 1'b0;
    force_x      <= '0;
    force_y      <= '0;
    force_z      <= '0;
    contact_prob <= '0;
    last_in_tick <= 1'b0;
    rx_wait_max  <= 3;
    tx_gap_max = 3;
    cur_contact_thr = CONTACT_THR_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset register values. The first tick runs
    // until the request flagged last; rates stay zero until then.
    offer_sample(3'd0, 1'b1, '0, '0, '0, 16'd0, 1'b0);
    offer_sample(3'd1, 1'b1, MAXF, '0, '0, 16'hFFFF, 1'b0);
    offer_sample(3'd2, 1'b1, MINF, '0, '0, 16'd0, 1'b0);
    offer_sample(3'd3, 1'b1, '0, MAXF, '0, 16'd32768, 1'b0);
    offer_sample(3'd4, 1'b1, '0, MINF, '0, 16'd32769, 1'b0);
    offer_sample(3'd5, 1'b1, '0, '0, MAXF, 16'd0, 1'b0);
    offer_sample(3'd6, 1'b1, '0, '0, MINF, 16'd0, 1'b0);
    offer_sample(3'd7, 1'b1, MINF, MINF, MINF, 16'hFFFF, 1'b1);
    // Rates now live: steepest rise, invalid request, steepest fall.
    offer_sample(3'd0, 1'b1, MAXF, MAXF, MAXF, 16'd0, 1'b0);
    offer_sample(3'd1, 1'b0, MAXF, MINF, MAXF, 16'hFFFF, 1'b0);
    offer_sample(3'd7, 1'b1, '0, '0, '0, 16'd0, 1'b0);
    offer_sample(3'd2, 1'b1, 24'sd1, '0, '0, 16'd0, 1'b0);
    offer_sample(3'd2, 1'b1, -24'sd1, -24'sd1, -24'sd1, 16'd0, 1'b0);
    offer_sample(3'd3, 1'b0, '0, '0, '0, 16'd0, 1'b1);
    offer_sample(3'd0, 1'b1, '0, '0, '0, 16'd0, 1'b0);
    offer_sample(3'd0, 1'b1, MAXF, MAXF, MAXF, 16'hFFFF, 1'b1);
    offer_sample(3'd0, 1'b1, MAXF, MAXF, MAXF, 16'd0, 1'b0);
    drain_pipeline();

    // Random phases, each under its own register setting. Early phases pin the
    // extremes: full and zero smoothing, alpha above one, zero and largest inv_dt.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          tx_gap_max = 0;
          rx_wait_max <= 0;
          load_settings(rand_threshold(), 16'd32768, 1'b1, ALPHA_ONE, 16'hFFFF);
        end
        1: begin
          tx_gap_max = 8;
          rx_wait_max <= 0;
          load_settings('0, '0, 1'b1, '0, 16'd1);
        end
        2: begin
          tx_gap_max = 8;
          rx_wait_max <= 8;
          load_settings(24'hFFFFFF, 16'hFFFF, 1'b1, 17'h1FFFF, 16'd500);
        end
        3: begin
          tx_gap_max = 0;
          rx_wait_max <= 8;
          load_settings(rand_threshold(), PROB_W'($urandom), 1'b0,
                        ALPHA_W'($urandom_range(0, 65536)), INVDT_W'($urandom_range(1, 65535)));
        end
        4: begin
          tx_gap_max = 8;
          rx_wait_max <= 8;
          load_settings(rand_threshold(), PROB_W'($urandom), 1'b1, ALPHA_ONE + 1'b1, '0);
        end
        default: begin
          tx_gap_max = 8;
          rx_wait_max <= 8;
          load_settings(rand_threshold(), PROB_W'($urandom), 1'($urandom_range(0, 1)),
                        ALPHA_W'($urandom_range(0, 131071)), INVDT_W'($urandom));
        end
      endcase
      run_ticks(PHASE_ITEMS);
      drain_pipeline();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d samples under %0d register settings: directed extremes, whole ticks",
             samples_sent, settings_used);
    $display("and stray samples; %0d results compared, %0d bad, %0d still awaited.",
             compared, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ffcc_pkg.sv
rtl/core/ffcc_isqrt.sv
rtl/core/fingertip_force_contact_conditioner_unit.sv
dv/contact_result_checker.sv
dv/tb_top.sv
